// ===== rtl/bir_pkg.sv =====
// ----------------------------------------------------------------------------
// bir_pkg
// Shared types and constants of the bounded index rejection sampler.
// ----------------------------------------------------------------------------
package bir_pkg;

  // Field widths of the items.
  localparam int unsigned WordW  = 16;
  localparam int unsigned CountW = 12;
  localparam int unsigned ProdW  = WordW + CountW;

  // Default depth of the spare word pool.
  localparam int unsigned PoolDepthDefault = 128;

  // Reset value of the index count register.
  localparam logic [CountW-1:0] IndexCountReset = 12'd508;

  // Opcodes carried on the input tuser.
  localparam logic OpStore   = 1'b0;
  localparam logic OpPrimary = 1'b1;

  // The remainder 65536 mod s is found one dividend bit per step.
  localparam int unsigned DivSteps = WordW + 1;
  localparam int unsigned StepW    = $clog2(DivSteps);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store_word;  // write the input word into the spare pool
    logic load_item;   // latch a primary word, its bound and position
    logic div_step;    // one restoring step of 65536 mod bound
    logic div_first;   // the step brings in the leading one of 65536
    logic mul_word;    // product of the primary word and the bound
    logic rd_issue;    // read the next spare word from the pool
    logic mul_spare;   // product of the spare word and the bound
    logic set_dry;     // a retry found the pool empty
    logic emit;        // load the output register and advance the run
  } bir_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic below;       // low half of the product is under the threshold
    logic pool_avail;  // an unread spare word is left
    logic out_free;    // the output register can take an item now
  } bir_status_t;

endpackage

// ===== rtl/bir_ram.sv =====
// ----------------------------------------------------------------------------
// bir_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module bir_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bir_ctrl.sv =====
// ----------------------------------------------------------------------------
// bir_ctrl
// Controller of the sampler: sequences the remainder steps, the retries from
// the spare pool and the hand-off to the output register.
// ----------------------------------------------------------------------------
module bir_ctrl import bir_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_op_i,
  output logic        in_ready_o,
  input  bir_status_t status_i,
  output bir_cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DIV   = 6'b000010,
    S_CHECK = 6'b000100,
    S_READ  = 6'b001000,
    S_MUL   = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e           state_q, state_d;
  logic [StepW-1:0] step_q, step_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_op_i == OpPrimary) begin
            cmd_o.load_item = 1'b1;
            step_d          = '0;
            state_d         = S_DIV;
          end else begin
            cmd_o.store_word = 1'b1;
          end
        end
      end
      S_DIV: begin
        cmd_o.div_step  = 1'b1;
        cmd_o.div_first = (step_q == '0);
        cmd_o.mul_word  = (step_q == '0);
        if (step_q == StepW'(DivSteps - 1)) begin
          state_d = S_CHECK;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_CHECK: begin
        if (status_i.below) begin
          if (status_i.pool_avail) begin
            cmd_o.rd_issue = 1'b1;
            state_d        = S_READ;
          end else begin
            cmd_o.set_dry = 1'b1;
            state_d       = S_DONE;
          end
        end else begin
          state_d = S_DONE;
        end
      end
      S_READ: begin
        state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_spare = 1'b1;
        state_d         = S_CHECK;
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

// ===== rtl/bir_dp.sv =====
// ----------------------------------------------------------------------------
// bir_dp
// Datapath of the sampler: count register, run position, pool pointers and
// pool RAM, the bit-serial remainder, the multiplier and the output register.
// ----------------------------------------------------------------------------
module bir_dp import bir_pkg::*; #(
  parameter int unsigned POOL_DEPTH = PoolDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_wdata_i,
  input  logic [WordW-1:0]  in_word_i,
  input  bir_cmd_t          cmd_i,
  output bir_status_t       status_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CountW-1:0] out_index_o,
  output logic [CountW-1:0] out_pos_o,
  output logic              out_last_o,
  output logic              out_dry_o
);

  localparam int unsigned AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int unsigned PW = $clog2(POOL_DEPTH + 1);

  logic [CountW-1:0] index_count_q;
  logic [CountW-1:0] run_pos_q, run_pos_d;
  logic [PW-1:0]     wptr_q, wptr_d;
  logic [PW-1:0]     rptr_q, rptr_d;
  logic [CountW-1:0] bound_q, pos_q, rem_q;
  logic [WordW-1:0]  word_q;
  logic [ProdW-1:0]  m_q;
  logic              dry_q;
  logic              out_valid_q;
  logic [CountW-1:0] out_index_q, out_pos_q;
  logic              out_last_q, out_dry_q;

  logic [CountW-1:0] count_c, pos_c;
  logic [CountW:0]   shifted_c;
  logic [WordW-1:0]  spare_c;
  logic              pool_full_c;
  logic              last_c;

  // Spare word pool.
  bir_ram #(
    .WIDTH(WordW),
    .DEPTH(POOL_DEPTH)
  ) u_pool (
    .clk_i  (clk_i),
    .we_i   (cmd_i.store_word && !pool_full_c),
    .waddr_i(wptr_q[AW-1:0]),
    .wdata_i(in_word_i),
    .re_i   (cmd_i.rd_issue),
    .raddr_i(rptr_q[AW-1:0]),
    .rdata_o(spare_c)
  );

  assign pool_full_c = (wptr_q == PW'(POOL_DEPTH));
  assign last_c      = (bound_q == CountW'(1));

  // Bound and position of a new primary word; a count of zero acts as one.
  assign count_c = (index_count_q == '0) ? CountW'(1) : index_count_q;
  assign pos_c   = (run_pos_q >= count_c) ? '0 : run_pos_q;

  // One restoring step of 65536 mod bound.
  assign shifted_c = {rem_q, cmd_i.div_first};

  assign status_o.below      = (m_q[WordW-1:0] < {{(WordW-CountW){1'b0}}, rem_q});
  assign status_o.pool_avail = (rptr_q < wptr_q);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_count_q <= IndexCountReset;
    end else if (cfg_we_i) begin
      index_count_q <= cfg_wdata_i;
    end
  end

  // Run position and pool pointers; the end of a run empties the pool.
  always_comb begin
    run_pos_d = run_pos_q;
    wptr_d    = wptr_q;
    rptr_d    = rptr_q;
    if (cmd_i.store_word && !pool_full_c) begin
      wptr_d = wptr_q + 1'b1;
    end
    if (cmd_i.rd_issue) begin
      rptr_d = rptr_q + 1'b1;
    end
    if (cmd_i.emit) begin
      if (last_c) begin
        run_pos_d = '0;
        wptr_d    = '0;
        rptr_d    = '0;
      end else begin
        run_pos_d = pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_pos_q <= '0;
      wptr_q    <= '0;
      rptr_q    <= '0;
    end else begin
      run_pos_q <= run_pos_d;
      wptr_q    <= wptr_d;
      rptr_q    <= rptr_d;
    end
  end

  // Working registers of the item in flight.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      word_q  <= in_word_i;
      bound_q <= count_c - pos_c;
      pos_q   <= pos_c;
      rem_q   <= '0;
    end
    if (cmd_i.div_step) begin
      if (shifted_c >= {1'b0, bound_q}) begin
        rem_q <= CountW'(shifted_c - {1'b0, bound_q});
      end else begin
        rem_q <= shifted_c[CountW-1:0];
      end
    end
    if (cmd_i.mul_word) begin
      m_q <= word_q * bound_q;
    end else if (cmd_i.mul_spare) begin
      m_q <= spare_c * bound_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dry_q <= 1'b0;
    end else if (cmd_i.load_item) begin
      dry_q <= 1'b0;
    end else if (cmd_i.set_dry) begin
      dry_q <= 1'b1;
    end
  end

  // Output register; a new item may replace one taken in the same cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_index_q <= dry_q ? '0 : m_q[ProdW-1:WordW];
      out_pos_q   <= pos_q;
      out_last_q  <= last_c;
      out_dry_q   <= dry_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_index_o = out_index_q;
  assign out_pos_o   = out_pos_q;
  assign out_last_o  = out_last_q;
  assign out_dry_o   = out_dry_q;

  // The read pointer never passes the fill count.
  assert property (@(posedge clk_i) disable iff (!rst_ni) rptr_q <= wptr_q)
    else $error("pool read pointer passed write pointer");

  // The fill count never exceeds the pool depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) wptr_q <= PW'(POOL_DEPTH))
    else $error("pool write pointer beyond depth");

  // A finished remainder is below the bound.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_i.emit |-> rem_q < bound_q)
    else $error("remainder not below bound");

  // An accepted index lies below its bound.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   cmd_i.emit && !dry_q |-> m_q[ProdW-1:WordW] < bound_q)
    else $error("index not below bound");

endmodule

// ===== rtl/bounded_index_rejection_sampler_unit.sv =====
// ----------------------------------------------------------------------------
// bounded_index_rejection_sampler_unit
// Unbiased shuffle index sampler with a spare word pool for retries.
// ----------------------------------------------------------------------------
// Usage:
// The input stream carries 16-bit random words; tuser is the opcode. An
// opcode of zero stores the word in the spare pool, unless the pool is full. An
// opcode of one is the primary word of the next index; it yields one output
// item with the index and its position (tdata), the end of run (tlast) and
// a pool-empty flag (tuser). The bound counts down from index_count to one.
// A primary word is accepted, then the bit-serial remainder 65536 mod bound
// is worked out, then the product is checked and the item handed off. Each
// retry from the pool adds a RAM read, a multiply and a check.
// One item is in work at a time; stores wait until the index is handed off.
// The output register holds a finished item while the receiver stalls. The
// block still accepts stores and one more primary word, works that word out
// and then waits in its hand-off step, taking no further item until the
// output register can take the new one.
// After reset the count is 508 and the run position and pool are empty;
// the end of a run empties the pool again. The user writes index_count only
// while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module bounded_index_rejection_sampler_unit import bir_pkg::*; #(
  parameter int unsigned POOL_DEPTH = PoolDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CountW-1:0]   cfg_wdata_i,   // index_count
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [WordW-1:0]    s_axis_tdata,  // [15:0] random_word
  input  logic                s_axis_tuser,  // [0] opcode
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [2*CountW-1:0] m_axis_tdata,  // [11:0] index_value, [23:12] position
  output logic                m_axis_tlast,  // last_of_run
  output logic                m_axis_tuser   // [0] pool_exhausted
);

  bir_cmd_t    cmd;
  bir_status_t status;
  logic        ready;

  // Sequencer.
  bir_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_op_i   (s_axis_tuser),
    .in_ready_o(ready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  // Storage and arithmetic.
  bir_dp #(
    .POOL_DEPTH(POOL_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_word_i  (s_axis_tdata),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_index_o(m_axis_tdata[CountW-1:0]),
    .out_pos_o  (m_axis_tdata[2*CountW-1:CountW]),
    .out_last_o (m_axis_tlast),
    .out_dry_o  (m_axis_tuser)
  );

  assign s_axis_tready = ready;

endmodule
